// ===== hw/rtl/usct_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere cell tessellator package
// Shared widths, fixed-point constants and codes for the tessellator.
// ----------------------------------------------------------------------------
package usct_pkg;

    localparam int ANGLE_W  = 16;
    localparam int SINE_W   = 16;
    localparam int COORD_W  = 25;
    localparam int RADIUS_W = 24;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int Q30_W    = 31;

    localparam logic [COUNT_W-1:0] MAX_DIVISIONS = 11'd1024;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [ANGLE_W-1:0] LAT_BASE     = 16'hC000;

    localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [Q30_W-1:0] K1 = 31'd1686629713;
    localparam logic [Q30_W-1:0] K3 = 31'd693598669;
    localparam logic [Q30_W-1:0] K5 = 31'd85569286;
    localparam logic [Q30_W-1:0] K7 = 31'd5026993;
    localparam logic [Q30_W-1:0] K9 = 31'd172272;

    localparam logic [1:0] REG_RADIUS      = 2'd0;
    localparam logic [1:0] REG_SLICE_COUNT = 2'd1;
    localparam logic [1:0] REG_STACK_COUNT = 2'd2;

    typedef enum logic [1:0] {
        MODE_MID    = 2'd0,
        MODE_BOTTOM = 2'd1,
        MODE_TOP    = 2'd2
    } cell_mode_t;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== hw/rtl/usct_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per register stage; the divisor is held static.
// ----------------------------------------------------------------------------
module usct_div
    import usct_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [26:0]        num,
    input  logic [COUNT_W-1:0] den,
    output logic [16:0]        quo
);

    localparam int NUM_W = 27;
    localparam int QBITS = 17;

    logic [NUM_W-1:0] rem_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS];

    for (genvar j = 0; j < QBITS; j++) begin : g_stage
        localparam int B = QBITS - 1 - j;
        logic [NUM_W:0]   rin;
        logic [QBITS-1:0] qin;
        logic [NUM_W:0]   sh;
        logic             ge;

        if (j == 0) begin : g_first
            assign rin = {1'b0, num};
            assign qin = '0;
        end
        else begin : g_rest
            assign rin = {1'b0, rem_reg[j-1]};
            assign qin = q_reg[j-1];
        end

        assign sh = (NUM_W+1)'(den) << B;
        assign ge = (rin >= sh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? NUM_W'(rin - sh) : NUM_W'(rin);
                q_reg[j]   <= qin | (QBITS'(ge) << B);
            end
        end
    end

    assign quo = q_reg[QBITS-1];

endmodule

// ===== hw/rtl/usct_sine.sv =====
// ----------------------------------------------------------------------------
// Pipelined fixed-point sine
// Quadrant fold, degree-9 odd polynomial in Q30, rounded to Q1.15.
// ----------------------------------------------------------------------------
module usct_sine
    import usct_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [SINE_W-1:0] sine
);

    logic [Q30_W-1:0] t_reg [1:6];
    logic             n_reg [1:6];
    logic [Q30_W-1:0] u_reg [2:5];
    logic [Q30_W-1:0] p_reg [3:6];

    logic [Q30_W-1:0] t_fold;
    logic [Q30_W-1:0] t_raw;
    logic [61:0]      sq;
    logic [61:0]      pr3, pr4, pr5, pr6, pr7;
    logic [31:0]      r_rnd;
    logic [16:0]      mag;
    logic [SINE_W-1:0] mag_sat;

    assign t_raw  = {1'b0, angle[ANGLE_W-3:0], 16'b0};
    assign t_fold = angle[ANGLE_W-2] ? ONE_Q30 - t_raw : t_raw;

    assign sq  = 62'(t_reg[1]) * 62'(t_reg[1]);
    assign pr3 = 62'(u_reg[2]) * 62'(K9);
    assign pr4 = 62'(u_reg[3]) * 62'(p_reg[3]);
    assign pr5 = 62'(u_reg[4]) * 62'(p_reg[4]);
    assign pr6 = 62'(u_reg[5]) * 62'(p_reg[5]);
    assign pr7 = 62'(t_reg[6]) * 62'(p_reg[6]);

    assign r_rnd   = 32'(pr7[60:30]) + 32'h0000_4000;
    assign mag     = r_rnd[31:15];
    assign mag_sat = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[1] <= t_fold;
            n_reg[1] <= angle[ANGLE_W-1];
            for (int i = 2; i <= 6; i++)
            begin
                t_reg[i] <= t_reg[i-1];
                n_reg[i] <= n_reg[i-1];
            end
            u_reg[2] <= sq[60:30];
            u_reg[3] <= u_reg[2];
            u_reg[4] <= u_reg[3];
            u_reg[5] <= u_reg[4];
            p_reg[3] <= K7 - pr3[60:30];
            p_reg[4] <= K5 - pr4[60:30];
            p_reg[5] <= K3 - pr5[60:30];
            p_reg[6] <= K1 - pr6[60:30];
            sine     <= n_reg[6] ? -$signed(mag_sat) : $signed(mag_sat);
        end
    end

endmodule

// ===== hw/rtl/uv_sphere_cell_tessellator_core.sv =====
// ----------------------------------------------------------------------------
// UV sphere cell tessellator
// Turns one (slice, stack) grid cell into its triangle vertices.
//
//   Channel   Dir  Signals                         Content
//   s_axis    in   tvalid tready tdata[23:0]       cell indices
//   m_axis    out  tvalid tready tdata[79:0] tlast vertex, tlast on final
//   cfg       in   cfg_wr_en cfg_index cfg_data    radius, slice/stack counts
//
// A cell passes 27 register stages: an input stage, a 17-stage divider for
// the corner angles, a 7-stage sine pipeline and two multiply stages.
// The output stage then sends one vertex per cycle while m_axis_tready is high,
// 3 or 6 vertices per cell, and takes a new cell as the final vertex is sent.
// Reset clears the valid bits and loads the register reset values.
// A stall at the output freezes the pipeline once its last stage holds a cell.
// ----------------------------------------------------------------------------
module uv_sphere_cell_tessellator_core
    import usct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // slice_index[9:0], stack_index[19:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // vertex_x[24:0], vertex_y[49:25], vertex_z[74:50]
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int LAT = 27;

    logic [RADIUS_W-1:0] radius_reg;
    logic [COUNT_W-1:0]  slice_count_reg;
    logic [COUNT_W-1:0]  stack_count_reg;
    logic [COUNT_W-1:0]  ns, nk;

    logic       vld_reg  [LAT];
    cell_mode_t mode_reg [LAT];
    logic [INDEX_W-1:0] s_reg, k_reg;

    logic adv, load, in_fire, out_fire, in_range, final_vtx;
    logic [INDEX_W-1:0] s_in, k_in;
    cell_mode_t mode_in;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= 24'd4096;
            slice_count_reg <= 11'd16;
            stack_count_reg <= 11'd16;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RADIUS:      radius_reg      <= cfg_data;
                REG_SLICE_COUNT: slice_count_reg <= cfg_data[COUNT_W-1:0];
                REG_STACK_COUNT: stack_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign ns = (slice_count_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : slice_count_reg;
    assign nk = (stack_count_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : stack_count_reg;

    assign s_in     = s_axis_tdata[9:0];
    assign k_in     = s_axis_tdata[19:10];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_range = (COUNT_W'(s_in) < ns) && (COUNT_W'(k_in) < nk);

    always_comb
    begin
        if (k_in == '0)
            mode_in = MODE_BOTTOM;
        else if (COUNT_W'(k_in) == nk - 11'd1)
            mode_in = MODE_TOP;
        else
            mode_in = MODE_MID;
    end

    assign adv           = !vld_reg[LAT-1] || load;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i]  <= 1'b0;
                mode_reg[i] <= MODE_MID;
            end
        end
        else if (adv)
        begin
            vld_reg[0]  <= in_fire && in_range;
            mode_reg[0] <= mode_in;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i]  <= vld_reg[i-1];
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= s_in;
            k_reg <= k_in;
        end
    end

    // corner angles: longitude of s and s+1, latitude of k and k+1
    logic [26:0] num_lon0, num_lon1, num_lat0, num_lat1;
    logic [16:0] q_lon0, q_lon1, q_lat0, q_lat1;

    assign num_lon0 = (27'(s_reg) << 16) + 27'(ns >> 1);
    assign num_lon1 = ((27'(s_reg) + 27'd1) << 16) + 27'(ns >> 1);
    assign num_lat0 = (27'(k_reg) << 15) + 27'(nk >> 1);
    assign num_lat1 = ((27'(k_reg) + 27'd1) << 15) + 27'(nk >> 1);

    usct_div u_div_lon0 (.clk(clk), .en(adv), .num(num_lon0), .den(ns), .quo(q_lon0));
    usct_div u_div_lon1 (.clk(clk), .en(adv), .num(num_lon1), .den(ns), .quo(q_lon1));
    usct_div u_div_lat0 (.clk(clk), .en(adv), .num(num_lat0), .den(nk), .quo(q_lat0));
    usct_div u_div_lat1 (.clk(clk), .en(adv), .num(num_lat1), .den(nk), .quo(q_lat1));

    logic [ANGLE_W-1:0] lon0, lon1, lat0, lat1;
    assign lon0 = q_lon0[ANGLE_W-1:0];
    assign lon1 = q_lon1[ANGLE_W-1:0];
    assign lat0 = q_lat0[ANGLE_W-1:0] + LAT_BASE;
    assign lat1 = q_lat1[ANGLE_W-1:0] + LAT_BASE;

    logic signed [SINE_W-1:0] so0, co0, so1, co1, sl0, cl0, sl1, cl1;

    usct_sine u_so0 (.clk(clk), .en(adv), .angle(lon0),                .sine(so0));
    usct_sine u_co0 (.clk(clk), .en(adv), .angle(lon0 + QUARTER_TURN), .sine(co0));
    usct_sine u_so1 (.clk(clk), .en(adv), .angle(lon1),                .sine(so1));
    usct_sine u_co1 (.clk(clk), .en(adv), .angle(lon1 + QUARTER_TURN), .sine(co1));
    usct_sine u_sl0 (.clk(clk), .en(adv), .angle(lat0),                .sine(sl0));
    usct_sine u_cl0 (.clk(clk), .en(adv), .angle(lat0 + QUARTER_TURN), .sine(cl0));
    usct_sine u_sl1 (.clk(clk), .en(adv), .angle(lat1),                .sine(sl1));
    usct_sine u_cl1 (.clk(clk), .en(adv), .angle(lat1 + QUARTER_TURN), .sine(cl1));

    // first multiply stage: radius times latitude terms
    logic signed [COORD_W-1:0] rad;
    logic signed [40:0] y0_reg, y1_reg, rc0_reg, rc1_reg;
    logic signed [SINE_W-1:0] so0_reg, co0_reg, so1_reg, co1_reg;

    assign rad = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y0_reg  <= rad * sl0;
            y1_reg  <= rad * sl1;
            rc0_reg <= rad * cl0;
            rc1_reg <= rad * cl1;
            so0_reg <= so0;
            co0_reg <= co0;
            so1_reg <= so1;
            co1_reg <= co1;
        end
    end

    function automatic coord_t rnd30(input logic signed [56:0] v);
        logic signed [56:0] w;
        w = v + 57'sd536870912;
        return w[54:30];
    endfunction

    function automatic coord_t rnd15(input logic signed [40:0] v);
        logic signed [40:0] w;
        w = v + 41'sd16384;
        return w[39:15];
    endfunction

    // second multiply stage: the four corners p1..p4
    coord_t cx_reg [4];
    coord_t cy_reg [4];
    coord_t cz_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= rnd30(57'(rc0_reg) * so0_reg);
            cz_reg[0] <= rnd30(57'(rc0_reg) * co0_reg);
            cy_reg[0] <= rnd15(y0_reg);
            cx_reg[1] <= rnd30(57'(rc0_reg) * so1_reg);
            cz_reg[1] <= rnd30(57'(rc0_reg) * co1_reg);
            cy_reg[1] <= rnd15(y0_reg);
            cx_reg[2] <= rnd30(57'(rc1_reg) * so1_reg);
            cz_reg[2] <= rnd30(57'(rc1_reg) * co1_reg);
            cy_reg[2] <= rnd15(y1_reg);
            cx_reg[3] <= rnd30(57'(rc1_reg) * so0_reg);
            cz_reg[3] <= rnd30(57'(rc1_reg) * co0_reg);
            cy_reg[3] <= rnd15(y1_reg);
        end
    end

    // output stage: walks the held corners in triangle order
    coord_t     ox_reg [4];
    coord_t     oy_reg [4];
    coord_t     oz_reg [4];
    cell_mode_t omode_reg;
    logic [2:0] idx_reg;
    logic       busy_reg;
    logic [1:0] sel;

    always_comb
    begin
        case (omode_reg)
            MODE_BOTTOM:
                case (idx_reg)
                    3'd0:    sel = 2'd2;
                    3'd1:    sel = 2'd3;
                    default: sel = 2'd0;
                endcase
            MODE_TOP:
                case (idx_reg)
                    3'd0:    sel = 2'd1;
                    3'd1:    sel = 2'd3;
                    default: sel = 2'd0;
                endcase
            default:
                case (idx_reg)
                    3'd0:    sel = 2'd0;
                    3'd1:    sel = 2'd1;
                    3'd2:    sel = 2'd2;
                    3'd3:    sel = 2'd2;
                    3'd4:    sel = 2'd3;
                    default: sel = 2'd0;
                endcase
        endcase
    end

    assign final_vtx = (omode_reg == MODE_MID) ? (idx_reg == 3'd5) : (idx_reg == 3'd2);
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign load      = vld_reg[LAT-1] && (!busy_reg || (out_fire && final_vtx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            omode_reg <= MODE_MID;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            omode_reg <= mode_reg[LAT-1];
        end
        else if (out_fire)
        begin
            if (final_vtx)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ox_reg[i] <= cx_reg[i];
                oy_reg[i] <= cy_reg[i];
                oz_reg[i] <= cz_reg[i];
            end
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tlast  = final_vtx;
    assign m_axis_tdata  = {5'b0, oz_reg[sel], oy_reg[sel], ox_reg[sel]};

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= 3'd5))
        else $error("vertex index beyond six");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (out_fire && final_vtx))
        else $error("new cell loaded over an unfinished one");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_fire && final_vtx && !vld_reg[LAT-1]) |=> !busy_reg)
        else $error("output stage stayed busy after the final vertex");
`endif

endmodule
